// ===== design/mesh_laplacian_smoother_unit_macros.svh =====
// Assertion macros shared by the checker of the mesh smoothing unit.
// Standalone header; no other file is needed to use it.
`ifndef MESH_LAPLACIAN_SMOOTHER_UNIT_MACROS_SVH
`define MESH_LAPLACIAN_SMOOTHER_UNIT_MACROS_SVH

// The consequent must hold in the clock cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// The consequent must hold in the same clock cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`endif

// ===== design/msm_pkg.sv =====
// Package of the mesh smoothing unit: request and result types, opcodes,
// register indexes and fixed widths. Depends on nothing else.
package msm_pkg;

	localparam int VALUE_BITS      = 16;
	localparam int NODE_FIELD_BITS = 10;
	localparam int SLOT_FIELD_BITS = 4;
	localparam int WEIGHT_BITS     = 10;
	localparam int DEGREE_BITS     = 5;
	localparam int BLEND_W         = VALUE_BITS + WEIGHT_BITS;
	localparam int CFG_ADDR_W      = 3;

	localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE    = 10'd1000;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET  = 10'd500;
	localparam logic [DEGREE_BITS-1:0] DEGREE_RESET  = 5'd6;

	localparam logic [1:0] OP_WRITE_VALUE = 2'd0;
	localparam logic [1:0] OP_WRITE_NBR   = 2'd1;
	localparam logic [1:0] OP_SMOOTH      = 2'd2;
	localparam logic [1:0] OP_SWAP        = 2'd3;

	localparam logic REG_WEIGHT = 1'b0;
	localparam logic REG_DEGREE = 1'b1;

	typedef struct packed {
		logic [1:0]                 op;
		logic [NODE_FIELD_BITS-1:0] node;
		logic [SLOT_FIELD_BITS-1:0] slot;
		logic [VALUE_BITS-1:0]      value;
		logic [NODE_FIELD_BITS-1:0] neighbour;
	} msm_request_t;

	typedef struct packed {
		logic [NODE_FIELD_BITS-1:0] result_node;
		logic [VALUE_BITS-1:0]      smoothed;
	} msm_result_t;

endpackage

// ===== design/msm_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No package dependency.
module msm_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/msm_div.sv =====
// Iterative restoring divider, two quotient bits per cycle.
// No package dependency; N must be even.
module msm_div #(
	parameter int N = 26,
	parameter int D = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quotient
);

	localparam int STEPS = N / 2;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D-1:0]     rem_q;
	logic [D-1:0]     dsr_q;
	logic [N-1:0]     quo_q;
	logic [D-1:0]     rem_n;
	logic [N-1:0]     quo_n;
	logic [D:0]       trial;

	// The dividend shifts out at the top of quo_q while quotient bits enter
	// at the bottom.
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, quo_n[N-1]};
			quo_n = {quo_n[N-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_n    = D'(trial - {1'b0, dsr_q});
				quo_n[0] = 1'b1;
			end else begin
				rem_n = trial[D-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(STEPS - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/mesh_laplacian_smoother_unit.sv =====
// Mesh smoothing unit: write value, write neighbour and swap bank requests finish in the
// accepting cycle. A smooth request keeps busy high until its write-back is done; the result
// strobe follows in the next cycle, when a new request may be taken.
// The rate is set by the single read port of the value memory (one neighbour per cycle) and,
// unless the degree is zero, by two passes through the shared two-bit-per-cycle divider.
// Asynchronous reset: idle, bank 0, weight 500, degree 6; the memories are not cleared.
module mesh_laplacian_smoother_unit #(
	parameter int NODE_COUNT     = 1024,
	parameter int MAX_NEIGHBOURS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  msm_pkg::msm_request_t            request,
	output logic                             result_strobe,
	output msm_pkg::msm_result_t             result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [msm_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	import msm_pkg::*;

	// Widths that follow from the mesh size.
	localparam int NODE_W   = $clog2(NODE_COUNT);
	localparam int DEG_W    = $clog2(MAX_NEIGHBOURS + 1);
	localparam int VADDR_W  = NODE_W + 1;
	localparam int NADDR_W  = $clog2(NODE_COUNT * MAX_NEIGHBOURS);
	localparam int SUM_W    = VALUE_BITS + DEG_W;
	localparam int DIVD_RAW = (SUM_W > BLEND_W) ? SUM_W : BLEND_W;
	localparam int DIVD_W   = DIVD_RAW + (DIVD_RAW % 2);
	localparam int DIVS_W   = (DEG_W > WEIGHT_BITS) ? DEG_W : WEIGHT_BITS;

	// Sequencer states of a smooth request.
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_OWN      = 3'd1;
	localparam logic [2:0] ST_GATHER   = 3'd2;
	localparam logic [2:0] ST_MEAN     = 3'd3;
	localparam logic [2:0] ST_MUL_OWN  = 3'd4;
	localparam logic [2:0] ST_MUL_MEAN = 3'd5;
	localparam logic [2:0] ST_SCALE    = 3'd6;
	localparam logic [2:0] ST_WRITE    = 3'd7;

	logic [2:0]             state_q;
	logic                   bank_q;
	logic [WEIGHT_BITS-1:0] weight_q;
	logic [DEGREE_BITS-1:0] degree_q;
	logic [DEG_W-1:0]       issue_q;
	logic                   own_pend_q;
	logic                   nbr_vld_s1;
	logic                   val_vld_s2;
	logic                   strobe_q;

	logic [NODE_W-1:0]      node_q;
	logic [DEG_W-1:0]       deg_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [VALUE_BITS-1:0]  own_q;
	logic [VALUE_BITS-1:0]  mean_q;
	logic [VALUE_BITS-1:0]  res_q;
	logic [SUM_W-1:0]       sum_q;
	logic [BLEND_W-1:0]     prod_q;
	msm_result_t            result_q;

	logic                   accept;
	logic                   node_ok;
	logic                   slot_ok;
	logic                   nbr_ok;
	logic [NODE_W-1:0]      node_idx;
	logic [DEG_W-1:0]       deg_clamp;
	logic [WEIGHT_BITS-1:0] w_clamp;
	logic                   cfg_wr;
	logic                   cfg_idx;
	logic                   gather_done;
	logic [BLEND_W-1:0]     blend;

	logic                   vm_we;
	logic [VADDR_W-1:0]     vm_waddr;
	logic [VALUE_BITS-1:0]  vm_wdata;
	logic                   vm_re;
	logic [VADDR_W-1:0]     vm_raddr;
	logic [VALUE_BITS-1:0]  vm_rdata;

	logic                   nt_we;
	logic [NADDR_W-1:0]     nt_waddr;
	logic                   nt_re;
	logic [NADDR_W-1:0]     nt_raddr;
	logic [NODE_W-1:0]      nt_rdata;

	logic                   div_start;
	logic [DIVD_W-1:0]      div_dividend;
	logic [DIVS_W-1:0]      div_divisor;
	logic                   div_done;
	logic [DIVD_W-1:0]      div_quotient;

	// A request is taken whenever start is high and the sequencer is idle.
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Out-of-range nodes make every request but a bank swap a no-op; an
	// out-of-range slot or neighbour index drops a neighbour write.
	assign node_ok  = (32'(request.node) < NODE_COUNT);
	assign slot_ok  = (32'(request.slot) < MAX_NEIGHBOURS);
	assign nbr_ok   = (32'(request.neighbour) < NODE_COUNT);
	assign node_idx = NODE_W'(request.node);

	// Register values above their legal range saturate.
	assign deg_clamp = (32'(degree_q) > MAX_NEIGHBOURS) ? DEG_W'(MAX_NEIGHBOURS)
		: DEG_W'(degree_q);
	assign w_clamp   = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;

	// Configuration port. Writes complete in the access phase; pready never
	// drops, and reads return the stored register.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[CFG_ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
			degree_q <= DEGREE_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WEIGHT: weight_q <= pwdata[WEIGHT_BITS-1:0];
				REG_DEGREE: degree_q <= pwdata[DEGREE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WEIGHT: prdata = 32'(weight_q);
			REG_DEGREE: prdata = 32'(degree_q);
			default:    prdata = '0;
		endcase
	end

	// Value memory: two banks side by side, the bank bit on top of the
	// address. Writes come from a value write request at acceptance or
	// from the write-back of a smoothed value into the other bank.
	assign vm_we    = (accept && (request.op == OP_WRITE_VALUE) && node_ok)
		|| (state_q == ST_WRITE);
	assign vm_waddr = (state_q == ST_WRITE) ? {~bank_q, node_q} : {bank_q, node_idx};
	assign vm_wdata = (state_q == ST_WRITE) ? res_q : request.value;

	// The read port first fetches the node's own value, then one neighbour
	// value per cycle as the neighbour indexes come back from the table.
	assign vm_re    = (state_q == ST_OWN) || nbr_vld_s1;
	assign vm_raddr = (state_q == ST_OWN) ? {bank_q, node_q} : {bank_q, nt_rdata};

	msm_ram #(
		.WIDTH  (VALUE_BITS),
		.DEPTH  (2 ** VADDR_W),
		.ADDR_W (VADDR_W)
	) u_value_mem (
		.clk   (clk),
		.we    (vm_we),
		.waddr (vm_waddr),
		.wdata (vm_wdata),
		.re    (vm_re),
		.raddr (vm_raddr),
		.rdata (vm_rdata)
	);

	// Neighbour table: one row of slots per node.
	assign nt_we    = accept && (request.op == OP_WRITE_NBR) && node_ok && slot_ok && nbr_ok;
	assign nt_waddr = NADDR_W'(32'(node_idx) * MAX_NEIGHBOURS + 32'(request.slot));
	assign nt_re    = (state_q == ST_GATHER) && (issue_q != deg_q);
	assign nt_raddr = NADDR_W'(32'(node_q) * MAX_NEIGHBOURS + 32'(issue_q));

	msm_ram #(
		.WIDTH  (NODE_W),
		.DEPTH  (NODE_COUNT * MAX_NEIGHBOURS),
		.ADDR_W (NADDR_W)
	) u_nbr_mem (
		.clk   (clk),
		.we    (nt_we),
		.waddr (nt_waddr),
		.wdata (NODE_W'(request.neighbour)),
		.re    (nt_re),
		.raddr (nt_raddr),
		.rdata (nt_rdata)
	);

	// The gather is over once every slot has been issued and the table and
	// value reads in flight, including the own-value read, have drained.
	assign gather_done = (issue_q == deg_q) && !nbr_vld_s1 && !val_vld_s2 && !own_pend_q;

	// The shared divider runs twice unless the degree is zero: sum over degree for
	// the mean, then the weighted blend over one thousand.
	assign blend        = prod_q + BLEND_W'(w_q) * BLEND_W'(mean_q);
	assign div_start    = ((state_q == ST_GATHER) && gather_done && (deg_q != '0))
		|| (state_q == ST_MUL_MEAN);
	assign div_dividend = (state_q == ST_GATHER) ? DIVD_W'(sum_q) : DIVD_W'(blend);
	assign div_divisor  = (state_q == ST_GATHER) ? DIVS_W'(deg_q) : DIVS_W'(WEIGHT_ONE);

	msm_div #(
		.N (DIVD_W),
		.D (DIVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Sequencer and read pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bank_q     <= 1'b0;
			issue_q    <= '0;
			own_pend_q <= 1'b0;
			nbr_vld_s1 <= 1'b0;
			val_vld_s2 <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			own_pend_q <= (state_q == ST_OWN);
			nbr_vld_s1 <= nt_re;
			val_vld_s2 <= nbr_vld_s1;
			strobe_q   <= (state_q == ST_WRITE);
			if (nt_re) begin
				issue_q <= issue_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					if (accept) begin
						if ((request.op == OP_SMOOTH) && node_ok) begin
							state_q <= ST_OWN;
						end else if (request.op == OP_SWAP) begin
							bank_q <= ~bank_q;
						end
					end
				end
				ST_OWN: state_q <= ST_GATHER;
				ST_GATHER: begin
					// A zero degree copies the node's own value unchanged.
					if (gather_done) begin
						state_q <= (deg_q == '0) ? ST_WRITE : ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (div_done) begin
						state_q <= ST_MUL_OWN;
					end
				end
				ST_MUL_OWN:  state_q <= ST_MUL_MEAN;
				ST_MUL_MEAN: state_q <= ST_SCALE;
				ST_SCALE: begin
					if (div_done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the request in progress.
	always_ff @(posedge clk) begin
		if (accept) begin
			node_q <= node_idx;
			deg_q  <= deg_clamp;
			w_q    <= w_clamp;
			sum_q  <= '0;
		end else if (val_vld_s2) begin
			sum_q <= sum_q + SUM_W'(vm_rdata);
		end
		if (own_pend_q) begin
			own_q <= vm_rdata;
		end
		if ((state_q == ST_MEAN) && div_done) begin
			mean_q <= div_quotient[VALUE_BITS-1:0];
		end
		if (state_q == ST_MUL_OWN) begin
			prod_q <= BLEND_W'(WEIGHT_ONE - w_q) * BLEND_W'(own_q);
		end
		if ((state_q == ST_SCALE) && div_done) begin
			res_q <= div_quotient[VALUE_BITS-1:0];
		end else if ((state_q == ST_GATHER) && gather_done && (deg_q == '0)) begin
			res_q <= own_q;
		end
		if (state_q == ST_WRITE) begin
			result_q.result_node <= NODE_FIELD_BITS'(node_q);
			result_q.smoothed    <= res_q;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

// ===== design/msm_checker.sv =====
// Port-level checker of the mesh smoothing unit and its bind statement.
// Depends on msm_pkg and on the assertion macro header.
`include "mesh_laplacian_smoother_unit_macros.svh"

module msm_checker #(
	parameter int NODE_COUNT = 1024
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input msm_pkg::msm_request_t request,
	input logic                  result_strobe
);

	import msm_pkg::*;

	logic take_smooth;
	logic take_short;

	assign take_smooth = start && !busy && (request.op == OP_SMOOTH)
		&& (32'(request.node) < NODE_COUNT);
	assign take_short  = start && !busy && (request.op != OP_SMOOTH);

	// A smooth request on a valid node occupies the unit.
	`ASSERT_NEXT(a_smooth_goes_busy, clk, arst_n, take_smooth, busy)
	// Other requests finish at once and report nothing.
	`ASSERT_NEXT(a_short_op_done, clk, arst_n, take_short, !busy && !result_strobe)
	// A result appears only once the unit is idle again.
	`ASSERT_SAME(a_strobe_when_idle, clk, arst_n, result_strobe, !busy)
	// Each smooth request gives exactly one result cycle.
	`ASSERT_NEXT(a_strobe_single, clk, arst_n, result_strobe, !result_strobe)
	// Leaving busy always comes with the result.
	`ASSERT_SAME(a_busy_end_reports, clk, arst_n, $fell(busy), result_strobe)

endmodule

bind mesh_laplacian_smoother_unit msm_checker #(
	.NODE_COUNT (NODE_COUNT)
) u_msm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.request       (request),
	.result_strobe (result_strobe)
);

// ===== verif/tb_mesh_laplacian_smoother_unit.sv =====
// Self-checking testbench for the mesh Laplacian smoothing unit.
// Depends on msm_pkg and mesh_laplacian_smoother_unit; drives requests and APB writes,
// and expects each smoothed result from its own copy of the mesh state or a typed-in value.
module tb_mesh_laplacian_smoother_unit;
	import msm_pkg::*;

	localparam int NODES         = 1024;
	localparam int SLOTS         = 16;
	localparam int WORK_NODES    = 24;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 186;
	// Longest smooth: sixteen neighbour reads plus the fixed divider overhead, with margin.
	localparam int SETTLE_CYCLES = 60;
	localparam int MAX_PRINTS    = 40;

	// One line of the directed table: either a register write or a request. Where the
	// outcome is obvious by inspection it is typed in; other rows use the predictor.
	typedef struct {
		bit                    is_cfg;
		logic                  cfg_reg;
		logic [31:0]           cfg_data;
		msm_request_t          req;
		bit                    typed;
		logic [VALUE_BITS-1:0] typed_smoothed;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	msm_request_t          request;
	logic                  result_strobe;
	msm_result_t           result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	mesh_laplacian_smoother_unit DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the mesh: both value banks, the neighbour table, the live bank and
	// the two registers. The written flags keep the stimulus away from reads of entries
	// that were never written.
	logic [VALUE_BITS-1:0]      node_value [2][NODES];
	bit                         value_set  [2][NODES];
	logic [NODE_FIELD_BITS-1:0] nbr_index  [NODES][SLOTS];
	bit                         nbr_set    [NODES][SLOTS];
	bit                         live_bank = 1'b0;
	logic [WEIGHT_BITS-1:0]     blend_weight = WEIGHT_RESET;
	logic [DEGREE_BITS-1:0]     degree_reg = DEGREE_RESET;

	// Smoothed results still owed by the block, oldest first.
	msm_result_t awaited_smooth [$];
	int          mismatches = 0;

	task automatic flag_mismatch(input string msg);
		if (mismatches < MAX_PRINTS) begin
			$display("%0t mismatch: %s", $time, msg);
		end
		mismatches++;
	endtask

	// A degree register above the slot count behaves as the full slot count.
	function automatic int eff_degree();
		return (degree_reg > SLOTS) ? SLOTS : int'(degree_reg);
	endfunction

	// Returns -1 when a smooth of node n reads only written entries, SLOTS when the node's
	// own value is missing, or else the first neighbour slot that is unusable.
	function automatic int first_gap(input logic [NODE_FIELD_BITS-1:0] n);
		int k;
		if (!value_set[live_bank][n]) begin
			return SLOTS;
		end
		for (k = 0; k < eff_degree(); k++) begin
			if (!nbr_set[n][k] || !value_set[live_bank][nbr_index[n][k]]) begin
				return k;
			end
		end
		return -1;
	endfunction

	// Applies one accepted request to the shadow mesh and, for a smooth, queues the
	// result that must come back (the typed value wins where the table gives one).
	function automatic void apply_to_mesh(input msm_request_t r, input bit typed,
			input logic [VALUE_BITS-1:0] typed_val);
		int unsigned own, w, deg, total, blended, k;
		msm_result_t want;
		case (r.op)
			OP_WRITE_VALUE: begin
				node_value[live_bank][r.node] = r.value;
				value_set[live_bank][r.node] = 1'b1;
			end
			OP_WRITE_NBR: begin
				nbr_index[r.node][r.slot] = r.neighbour;
				nbr_set[r.node][r.slot] = 1'b1;
			end
			OP_SMOOTH: begin
				own = 32'(node_value[live_bank][r.node]);
				w = (blend_weight > WEIGHT_ONE) ? int'(WEIGHT_ONE) : int'(blend_weight);
				deg = eff_degree();
				blended = own;
				if (deg != 0) begin
					total = 0;
					for (k = 0; k < deg; k++) begin
						total += 32'(node_value[live_bank][nbr_index[r.node][k]]);
					end
					// Mean first (truncated), then the blend in thousandths (truncated).
					blended = ((1000 - w) * own + w * (total / deg)) / 1000;
				end
				node_value[live_bank ^ 1'b1][r.node] = blended[VALUE_BITS-1:0];
				value_set[live_bank ^ 1'b1][r.node] = 1'b1;
				want.result_node = r.node;
				want.smoothed = typed ? typed_val : blended[VALUE_BITS-1:0];
				awaited_smooth.push_back(want);
			end
			default: begin
				live_bank ^= 1'b1;
			end
		endcase
	endfunction

	// Presents one request and holds it until the block takes it, that is at the first
	// rising edge with start high and busy low. Start is left high so that back-to-back
	// requests need no second assignment in the same step.
	task automatic issue(input msm_request_t r, input bit typed,
			input logic [VALUE_BITS-1:0] typed_val);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		apply_to_mesh(r, typed, typed_val);
	endtask

	// Register writes happen only with the block idle: every smooth has reported and a
	// further pause covers the longest request in flight. The register is then read back.
	task automatic program_register(input logic idx, input logic [31:0] data);
		logic [31:0] field_mask;
		field_mask = (idx == REG_WEIGHT) ? 32'h3FF : 32'h1F;
		start <= 1'b0;
		while (awaited_smooth.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (idx == REG_WEIGHT) begin
			blend_weight = data[WEIGHT_BITS-1:0];
		end else begin
			degree_reg = data[DEGREE_BITS-1:0];
		end
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== (data & field_mask)) begin
			flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata,
				data & field_mask));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic directed_row_t req_row(input logic [1:0] op,
			input logic [NODE_FIELD_BITS-1:0] node, input logic [SLOT_FIELD_BITS-1:0] slot,
			input logic [VALUE_BITS-1:0] value, input logic [NODE_FIELD_BITS-1:0] nbr,
			input bit typed, input logic [VALUE_BITS-1:0] typed_val);
		directed_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_reg = REG_WEIGHT;
		row.cfg_data = '0;
		row.req = '{op: op, node: node, slot: slot, value: value, neighbour: nbr};
		row.typed = typed;
		row.typed_smoothed = typed_val;
		return row;
	endfunction

	function automatic directed_row_t cfg_row(input logic idx, input logic [31:0] data);
		directed_row_t row;
		row = req_row(OP_SWAP, '0, '0, '0, '0, 1'b0, '0);
		row.is_cfg = 1'b1;
		row.cfg_reg = idx;
		row.cfg_data = data;
		return row;
	endfunction

	// Every result strobe is compared against the oldest outstanding expectation.
	always @(posedge clk) begin : result_check
		msm_result_t want;
		if (arst_n === 1'b1 && result_strobe === 1'b1) begin
			if (awaited_smooth.size() == 0) begin
				flag_mismatch($sformatf("unexpected result node %0d value %h",
					result.result_node, result.smoothed));
			end else begin
				want = awaited_smooth.pop_front();
				if (result.result_node !== want.result_node) begin
					flag_mismatch($sformatf("result_node %0d, expected %0d",
						result.result_node, want.result_node));
				end
				if (result.smoothed !== want.smoothed) begin
					flag_mismatch($sformatf("node %0d smoothed %h, expected %h",
						want.result_node, result.smoothed, want.smoothed));
				end
			end
		end
	end

	initial begin : stimulus
		directed_row_t              plan [$];
		logic [NODE_FIELD_BITS-1:0] work_nodes [WORK_NODES];
		int                         phase_weight [PHASES];
		int                         phase_degree [PHASES];
		msm_request_t               r;
		int                         p, i, k, gap, idle_pct, pick;
		logic [31:0]                junk;

		start <= 1'b0;
		request <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Starts from reset (weight 500, degree 6, bank 0) and walks the
		// value and index extremes, the zero-degree copy, full weight, the weight and
		// degree registers beyond their limits, a bank swap, a zero weight and an ordinary blend.
		plan.push_back(req_row(OP_WRITE_VALUE, 10'd0, 4'd0, 16'hFFFF, 10'd0, 1'b0, '0));
		plan.push_back(req_row(OP_WRITE_VALUE, 10'd1023, 4'd15, 16'h0000, 10'd1023, 1'b0, '0));
		plan.push_back(cfg_row(REG_DEGREE, 32'd0));
		// With no neighbours in use each node keeps its own value.
		plan.push_back(req_row(OP_SMOOTH, 10'd0, 4'd0, 16'h0, 10'd0, 1'b1, 16'hFFFF));
		plan.push_back(req_row(OP_SMOOTH, 10'd1023, 4'd0, 16'h0, 10'd0, 1'b1, 16'h0000));
		plan.push_back(cfg_row(REG_WEIGHT, 32'd1000));
		plan.push_back(cfg_row(REG_DEGREE, 32'd1));
		plan.push_back(req_row(OP_WRITE_NBR, 10'd0, 4'd0, 16'h0, 10'd1023, 1'b0, '0));
		plan.push_back(req_row(OP_WRITE_NBR, 10'd1023, 4'd0, 16'hFFFF, 10'd0, 1'b0, '0));
		// Full weight: the result is the neighbour mean alone.
		plan.push_back(req_row(OP_SMOOTH, 10'd0, 4'd0, 16'h0, 10'd0, 1'b1, 16'h0000));
		plan.push_back(req_row(OP_SMOOTH, 10'd1023, 4'd0, 16'h0, 10'd0, 1'b1, 16'hFFFF));
		plan.push_back(req_row(OP_SWAP, 10'd0, 4'd0, 16'h0, 10'd0, 1'b0, '0));
		// Weight 1023 acts as 1000 and degree 31 as sixteen slots, all pointing at 1023.
		plan.push_back(cfg_row(REG_WEIGHT, 32'd1023));
		plan.push_back(cfg_row(REG_DEGREE, 32'd31));
		for (k = 1; k < SLOTS; k++) begin
			plan.push_back(req_row(OP_WRITE_NBR, 10'd0, SLOT_FIELD_BITS'(k), 16'h0,
				10'd1023, 1'b0, '0));
		end
		plan.push_back(req_row(OP_SMOOTH, 10'd0, 4'd0, 16'h0, 10'd0, 1'b1, 16'hFFFF));
		// Zero weight leaves the node's own value untouched.
		plan.push_back(cfg_row(REG_WEIGHT, 32'd0));
		plan.push_back(cfg_row(REG_DEGREE, 32'd1));
		plan.push_back(req_row(OP_SMOOTH, 10'd1023, 4'd0, 16'h0, 10'd0, 1'b1, 16'hFFFF));
		// An ordinary blend, left to the predictor.
		plan.push_back(cfg_row(REG_WEIGHT, 32'd300));
		plan.push_back(req_row(OP_SMOOTH, 10'd0, 4'd0, 16'h0, 10'd0, 1'b0, '0));

		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].is_cfg) begin
				program_register(plan[i].cfg_reg, plan[i].cfg_data);
			end else begin
				issue(plan[i].req, plan[i].typed, plan[i].typed_smoothed);
			end
		end

		// Build a working mesh: a set of nodes (the two end indexes among them) with
		// values in both banks and all sixteen slots pointing inside the set. After this
		// every smooth on the set is legal whatever the degree.
		work_nodes[0] = 10'd0;
		work_nodes[1] = 10'd1023;
		for (i = 2; i < WORK_NODES; i++) begin
			work_nodes[i] = NODE_FIELD_BITS'($urandom_range(0, NODES - 1));
		end
		for (p = 0; p < 2; p++) begin
			for (i = 0; i < WORK_NODES; i++) begin
				r = msm_request_t'({$urandom, $urandom});
				r.op = OP_WRITE_VALUE;
				r.node = work_nodes[i];
				issue(r, 1'b0, '0);
			end
			r.op = OP_SWAP;
			issue(r, 1'b0, '0);
		end
		for (i = 0; i < WORK_NODES; i++) begin
			for (k = 0; k < SLOTS; k++) begin
				r = msm_request_t'({$urandom, $urandom});
				r.op = OP_WRITE_NBR;
				r.node = work_nodes[i];
				r.slot = SLOT_FIELD_BITS'(k);
				r.neighbour = work_nodes[$urandom_range(0, WORK_NODES - 1)];
				issue(r, 1'b0, '0);
			end
		end

		// Register settings per phase: the extremes first, then random ones.
		phase_weight = '{0, 1000, 1023, 500, 0, 0, 0, 0};
		phase_degree = '{16, 1, 31, 0, 0, 0, 0, 0};
		for (p = 4; p < PHASES; p++) begin
			phase_weight[p] = $urandom_range(0, 1023);
			phase_degree[p] = $urandom_range(0, 31);
		end

		for (p = 0; p < PHASES; p++) begin
			// Upper data bits are sometimes junk; the registers keep only their own width.
			junk = $urandom_range(0, 1) ? ($urandom & ~32'h3FF) : 32'd0;
			program_register(REG_WEIGHT, junk | 32'(phase_weight[p]));
			junk = $urandom_range(0, 1) ? ($urandom & ~32'h1F) : 32'd0;
			program_register(REG_DEGREE, junk | 32'(phase_degree[p]));
			// Sender gaps vary by phase; the final phase runs back to back.
			idle_pct = (p == PHASES - 1) ? 0 : ((p % 3) * 20);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 7)) @(posedge clk);
				end
				// Fields the operation ignores still carry random bits.
				r = msm_request_t'({$urandom, $urandom});
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// Smooth a node of the working set. If an earlier neighbour write
					// pointed it at an unwritten node, patch that slot (or the node's own
					// value) instead, so no unwritten entry is ever read.
					r.node = work_nodes[$urandom_range(0, WORK_NODES - 1)];
					gap = first_gap(r.node);
					if (gap < 0) begin
						r.op = OP_SMOOTH;
					end else if (gap == SLOTS) begin
						r.op = OP_WRITE_VALUE;
					end else begin
						r.op = OP_WRITE_NBR;
						r.slot = SLOT_FIELD_BITS'(gap);
						r.neighbour = work_nodes[$urandom_range(0, WORK_NODES - 1)];
					end
				end else if (pick < 65) begin
					r.op = OP_WRITE_VALUE;
					if ($urandom_range(0, 4) != 0) begin
						r.node = work_nodes[$urandom_range(0, WORK_NODES - 1)];
					end
					case ($urandom_range(0, 9))
						0: r.value = '0;
						1: r.value = '1;
						default: ;
					endcase
				end else if (pick < 92) begin
					// Mostly rewiring inside the set; now and then a link to an arbitrary
					// node, which may break the set until it is patched.
					r.op = OP_WRITE_NBR;
					if ($urandom_range(0, 4) != 0) begin
						r.node = work_nodes[$urandom_range(0, WORK_NODES - 1)];
					end
					if ($urandom_range(0, 6) != 0) begin
						r.neighbour = work_nodes[$urandom_range(0, WORK_NODES - 1)];
					end
				end else begin
					r.op = OP_SWAP;
				end
				issue(r, 1'b0, '0);
			end
		end

		// Drain: every smooth must report within a bounded time, then a quiet spell
		// catches any stray strobe.
		start <= 1'b0;
		for (i = 0; i < 4000 && awaited_smooth.size() != 0; i++) @(posedge clk);
		if (awaited_smooth.size() != 0) begin
			flag_mismatch($sformatf("%0d smoothed results never arrived",
				awaited_smooth.size()));
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Backstop against a hung handshake; far beyond the slowest legal run.
	initial begin : watchdog
		#20000000;
		$display("run timed out");
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== mesh_laplacian_smoother_unit.f =====
+incdir+design
design/msm_pkg.sv
design/msm_ram.sv
design/msm_div.sv
design/mesh_laplacian_smoother_unit.sv
design/msm_checker.sv
verif/tb_mesh_laplacian_smoother_unit.sv
